FILE: rtl/core/ssi_pkg.sv
// shared constants, types and control structs for the sorted index set intersection
package ssi_pkg;

   localparam int LIST_CAPACITY = 2048;
   localparam int INDEX_BITS    = 16;
   localparam int ADDR_BITS     = $clog2(LIST_CAPACITY);
   localparam int COUNT_BITS    = $clog2(LIST_CAPACITY + 1);
   localparam int TOTAL_BITS    = 12;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PROBE = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load_we;
      logic probe_take;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic advance;
      logic rsp_full;
      logic rsp_hold;
   } status_type;

endpackage

FILE: rtl/core/ssi_ctrl.sv
// controller state machine: accepts transactions and sequences the merge scan
module ssi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_stall,
   input  ssi_pkg::status_type status,
   output ssi_pkg::cmd_type    cmd
);

   ssi_pkg::state_type state_ff;
   ssi_pkg::state_type state_in;
   logic               take;

   // a probe needs the result register free, a load does not
   assign req_stall = (state_ff != ssi_pkg::ST_IDLE) ||
                      (status.rsp_hold && (req_kind == ssi_pkg::KIND_PROBE));
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssi_pkg::ST_IDLE: begin
            if (take && (req_kind == ssi_pkg::KIND_PROBE)) state_in = ssi_pkg::ST_SCAN;
         end
         ssi_pkg::ST_SCAN: begin
            if (!status.advance) state_in = ssi_pkg::ST_IDLE;
         end
         default: state_in = ssi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ssi_pkg::ST_IDLE: begin
            cmd.load_we    = take && (req_kind == ssi_pkg::KIND_LOAD);
            cmd.probe_take = take && (req_kind == ssi_pkg::KIND_PROBE);
         end
         ssi_pkg::ST_SCAN: begin
            cmd.scan_step = status.advance;
            cmd.finish    = !status.advance;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // result register must be empty while a probe is scanning
   a_scan_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssi_pkg::ST_SCAN) |-> !status.rsp_full)
      else $error("result register occupied during scan");

   // a probe always leaves the scan with a finish
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ssi_pkg::ST_SCAN) && !status.advance) |=> (state_ff == ssi_pkg::ST_IDLE))
      else $error("scan did not return to idle");

   a_scan_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssi_pkg::ST_SCAN) |-> req_stall)
      else $error("input open during scan");
`endif

endmodule

FILE: rtl/core/ssi_dp.sv
// datapath: list memory, merge pointer, counters and result register
module ssi_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ssi_pkg::cmd_type                  cmd,
   output ssi_pkg::status_type               status,
   input  logic [ssi_pkg::INDEX_BITS-1:0]    req_index_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   output logic [ssi_pkg::INDEX_BITS-1:0]    rsp_result_value,
   output logic [ssi_pkg::TOTAL_BITS-1:0]    rsp_match_total,
   output logic                              rsp_done_res,
   output logic                              rsp_overflowed
);

   logic [ssi_pkg::INDEX_BITS-1:0] mem [ssi_pkg::LIST_CAPACITY];
   logic [ssi_pkg::INDEX_BITS-1:0] rd_data_ff;

   logic [ssi_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [ssi_pkg::COUNT_BITS-1:0] scan_ff, scan_in;
   logic [ssi_pkg::TOTAL_BITS-1:0] match_ff, match_in;
   logic                           overflow_ff, overflow_in;

   logic [ssi_pkg::INDEX_BITS-1:0] probe_value_ff;
   logic                           probe_last_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_matched_ff;
   logic [ssi_pkg::INDEX_BITS-1:0] rsp_value_ff;
   logic [ssi_pkg::TOTAL_BITS-1:0] rsp_total_ff;
   logic                           rsp_done_ff;
   logic                           rsp_overflow_ff;

   logic full;
   logic in_range;
   logic hit;
   logic job_end;

   assign full     = (count_ff == ssi_pkg::COUNT_BITS'(ssi_pkg::LIST_CAPACITY));
   assign in_range = (scan_ff < count_ff);
   assign hit      = in_range && (rd_data_ff == probe_value_ff);
   assign job_end  = cmd.finish && probe_last_ff;

   assign status.advance  = in_range && (rd_data_ff < probe_value_ff);
   assign status.rsp_full = rsp_valid_ff;
   assign status.rsp_hold = rsp_valid_ff && rsp_stall;

   always_comb begin
      priority if (job_end) begin
         scan_in = '0;
      end else if (cmd.scan_step || (cmd.finish && hit)) begin
         scan_in = scan_ff + 1'b1;
      end else begin
         scan_in = scan_ff;
      end
   end

   always_comb begin
      priority if (job_end) begin
         count_in = '0;
      end else if (cmd.load_we && !full) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      priority if (job_end) begin
         match_in = '0;
      end else if (cmd.finish && hit) begin
         match_in = match_ff + 1'b1;
      end else begin
         match_in = match_ff;
      end
   end

   always_comb begin
      priority if (job_end) begin
         overflow_in = 1'b0;
      end else if (cmd.load_we && full) begin
         overflow_in = 1'b1;
      end else begin
         overflow_in = overflow_ff;
      end
   end

   // read port follows the next pointer so the entry is ready in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.load_we && !full) begin
         mem[count_ff[ssi_pkg::ADDR_BITS-1:0]] <= req_index_value;
      end
      rd_data_ff <= mem[scan_in[ssi_pkg::ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         scan_ff     <= '0;
         match_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         scan_ff     <= scan_in;
         match_ff    <= match_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe_take) begin
         probe_value_ff <= req_index_value;
         probe_last_ff  <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_matched_ff  <= hit;
         rsp_value_ff    <= probe_value_ff;
         rsp_total_ff    <= match_ff + ssi_pkg::TOTAL_BITS'(hit);
         rsp_done_ff     <= probe_last_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_match_total  = rsp_total_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_overflowed   = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssi_pkg::COUNT_BITS'(ssi_pkg::LIST_CAPACITY))
      else $error("stored count beyond capacity");

   // merge pointer never passes the end of the stored list
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= count_ff)
      else $error("scan pointer beyond stored count");

   a_job_clear: assert property (@(posedge clock) disable iff (reset)
      job_end |=> ((count_ff == '0) && (scan_ff == '0) && (match_ff == '0) && !overflow_ff))
      else $error("job state not cleared after last probe");
`endif

endmodule

FILE: rtl/core/sorted_index_set_intersection.sv
// top level: two-pointer merge intersection of two ascending index lists
// load transaction: one per cycle back to back while no probe is scanning, no result
// probe transaction: accepted in idle, the scan state steps past each smaller stored entry, result registered on finish
// each skip uses the single memory read port; the next item is taken once the scan is back in idle
// the merge pointer only moves forward, so each stored entry is passed once per job
// synchronous reset clears the counters, pointer, flags and result valid; list memory not cleared
module sorted_index_set_intersection (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [ssi_pkg::INDEX_BITS-1:0]    req_index_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   output logic [ssi_pkg::INDEX_BITS-1:0]    rsp_result_value,
   output logic [ssi_pkg::TOTAL_BITS-1:0]    rsp_match_total,
   output logic                              rsp_done_res,
   output logic                              rsp_overflowed
);

   ssi_pkg::cmd_type    cmd;
   ssi_pkg::status_type status;

   ssi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_index_value  (req_index_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_result_value (rsp_result_value),
      .rsp_match_total  (rsp_match_total),
      .rsp_done_res     (rsp_done_res),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

FILE: test/tb_sorted_index_set_intersection.sv
// testbench for the sorted index set intersection: directed and random jobs against a merge tracker
module tb_sorted_index_set_intersection;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [ssi_pkg::INDEX_BITS-1:0] index_type;
   typedef logic [ssi_pkg::TOTAL_BITS-1:0] total_type;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam index_type   INDEX_MAX   = '1;

   typedef struct packed {
      logic      matched;
      index_type value;
      total_type total;
      logic      done;
      logic      overflowed;
   } probe_outcome_type;

   // keeps its own copy of the stored list and merge pointer, queues one outcome per probe
   class intersection_tracker;
      index_type         stored_list [ssi_pkg::LIST_CAPACITY];
      int unsigned       stored_count;
      int unsigned       scan_position;
      total_type         match_counter;
      logic              overflow_flag;
      probe_outcome_type pending_outcomes [$];
      int unsigned       error_count;

      function new();
         error_count = 0;
         clear_job();
      endfunction

      function void clear_job();
         stored_count  = 0;
         scan_position = 0;
         match_counter = '0;
         overflow_flag = 1'b0;
      endfunction

      function void note_item(logic kind, index_type value, logic last);
         probe_outcome_type outcome;
         if (kind == ssi_pkg::KIND_LOAD) begin
            if (stored_count < ssi_pkg::LIST_CAPACITY) begin
               stored_list[stored_count] = value;
               stored_count++;
            end else begin
               overflow_flag = 1'b1;
            end
            return;
         end
         while (scan_position < stored_count && stored_list[scan_position] < value)
            scan_position++;
         outcome.matched = 1'b0;
         // an equal entry is consumed so duplicates pair one to one
         if (scan_position < stored_count && stored_list[scan_position] == value) begin
            outcome.matched = 1'b1;
            scan_position++;
            match_counter++;
         end
         outcome.value      = value;
         outcome.total      = match_counter;
         outcome.done       = last;
         outcome.overflowed = overflow_flag;
         pending_outcomes.push_back(outcome);
         if (last)
            clear_job();
      endfunction

      function void check_result(probe_outcome_type seen);
         probe_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $error("result transaction with nothing pending, value %0d", seen.value);
            error_count++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (seen.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, seen.matched);
            error_count++;
         end
         if (seen.value !== want.value) begin
            $error("result_value: expected %0d, actual %0d", want.value, seen.value);
            error_count++;
         end
         if (seen.total !== want.total) begin
            $error("match_total: expected %0d, actual %0d", want.total, seen.total);
            error_count++;
         end
         if (seen.done !== want.done) begin
            $error("done_res: expected %0d, actual %0d", want.done, seen.done);
            error_count++;
         end
         if (seen.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, actual %0d", want.overflowed, seen.overflowed);
            error_count++;
         end
      endfunction

      function int unsigned pending_count();
         return pending_outcomes.size();
      endfunction
   endclass

   logic      clock           = 1'b0;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_stall;
   logic      req_kind        = ssi_pkg::KIND_LOAD;
   index_type req_index_value = '0;
   logic      req_last        = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall       = 1'b0;
   logic      rsp_matched;
   index_type rsp_result_value;
   total_type rsp_match_total;
   logic      rsp_done_res;
   logic      rsp_overflowed;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned sent_count    = 0;
   int unsigned cycle_count   = 0;

   intersection_tracker tracker = new();

   sorted_index_set_intersection u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_index_value  (req_index_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_result_value (rsp_result_value),
      .rsp_match_total  (rsp_match_total),
      .rsp_done_res     (rsp_done_res),
      .rsp_overflowed   (rsp_overflowed)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(probe_outcome_type'{rsp_matched, rsp_result_value,
                                                  rsp_match_total, rsp_done_res,
                                                  rsp_overflowed});
   end

   function automatic index_type step_up(index_type base, int unsigned d);
      if (int'(base) + d > int'(INDEX_MAX))
         return INDEX_MAX;
      return base + index_type'(d);
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction is taken
   task automatic send_item(input logic kind, input index_type value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_index_value <= value;
      req_last        <= last;
      do
         @(posedge clock);
      while (req_stall);
      tracker.note_item(kind, value, last);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic run_random_items(input int unsigned count);
      int unsigned stop_at;
      int          style;
      int          n_load;
      int          n_probe;
      index_type   load_tail;
      index_type   probe_tail;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         style = $urandom_range(0, 9);
         if (style == 0) begin
            // noise: any kind, any value, stray last bits
            repeat ($urandom_range(1, 8))
               send_item(1'($urandom_range(0, 1)), index_type'($urandom),
                         $urandom_range(0, 3) == 0);
         end else begin
            case ($urandom_range(0, 3))
               0: load_tail = '0;
               1: load_tail = INDEX_MAX - index_type'(24);
               default: load_tail = index_type'($urandom);
            endcase
            probe_tail = load_tail;
            n_load     = $urandom_range(0, 12);
            n_probe    = $urandom_range(1, 12);
            // style 1 gives unsorted lists, the rest ascending lists in a shared window
            for (int i = 0; i < n_load; i++) begin
               load_tail = (style == 1) ? index_type'($urandom)
                                        : step_up(load_tail, $urandom_range(0, 3));
               send_item(ssi_pkg::KIND_LOAD, load_tail,
                         (i == n_load - 1) && $urandom_range(0, 1));
            end
            for (int i = 0; i < n_probe; i++) begin
               // late load lands behind the scan pointer
               if ($urandom_range(0, 7) == 0) begin
                  load_tail = step_up(load_tail, $urandom_range(0, 3));
                  send_item(ssi_pkg::KIND_LOAD, load_tail, 1'b0);
               end
               probe_tail = (style == 1) ? index_type'($urandom)
                                         : step_up(probe_tail, $urandom_range(0, 3));
               send_item(ssi_pkg::KIND_PROBE, probe_tail, i == n_probe - 1);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 82;

      // empty store: every probe misses
      send_item(ssi_pkg::KIND_PROBE, '0, 1'b0);
      send_item(ssi_pkg::KIND_PROBE, INDEX_MAX, 1'b1);
      // duplicates pair up, last on a load is ignored
      send_item(ssi_pkg::KIND_LOAD, '0, 1'b0);
      send_item(ssi_pkg::KIND_LOAD, '0, 1'b0);
      send_item(ssi_pkg::KIND_LOAD, index_type'(5), 1'b0);
      send_item(ssi_pkg::KIND_LOAD, INDEX_MAX, 1'b1);
      send_item(ssi_pkg::KIND_PROBE, '0, 1'b0);
      send_item(ssi_pkg::KIND_PROBE, '0, 1'b0);
      send_item(ssi_pkg::KIND_PROBE, '0, 1'b0);
      send_item(ssi_pkg::KIND_PROBE, index_type'(3), 1'b0);
      send_item(ssi_pkg::KIND_PROBE, index_type'(5), 1'b0);
      send_item(ssi_pkg::KIND_PROBE, INDEX_MAX, 1'b0);
      send_item(ssi_pkg::KIND_LOAD, INDEX_MAX, 1'b0);
      send_item(ssi_pkg::KIND_PROBE, INDEX_MAX, 1'b1);
      // unsorted store: the pointer never moves back
      send_item(ssi_pkg::KIND_LOAD, index_type'(10), 1'b0);
      send_item(ssi_pkg::KIND_LOAD, index_type'(3), 1'b0);
      send_item(ssi_pkg::KIND_PROBE, index_type'(3), 1'b0);
      send_item(ssi_pkg::KIND_PROBE, index_type'(10), 1'b1);

      run_random_items(320);

      send_idle_pct = 82;
      recv_idle_pct = 11;
      run_random_items(320);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_items(310);

      req_valid <= 1'b0;
      while (tracker.pending_count() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (tracker.error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
